>>> rtl/bqc_pkg.sv
// Package for the biquad cascade filter core: shared constants, codes and the
// control struct passed from the sequencer to the multiply-accumulate unit.
// No dependencies.
package bqc_pkg;

    // Default sizes, handed to the top-level parameters.
    localparam int MAX_SECTIONS_DEF = 8;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int COEF_WIDTH_DEF   = 24;

    // Fixed number formats.
    localparam int GUARD_BITS        = 8;
    localparam int COEF_INT_BITS     = 4;
    localparam int COEFS_PER_SECTION = 5;

    // Width of fields whose width the item format fixes.
    localparam int OPCODE_W  = 2;
    localparam int SEC_SEL_W = 3;
    localparam int COEF_SEL_W = 3;
    localparam int SEC_COUNT_W = 4;
    localparam int CFG_IDX_W = 1;

    // Opcodes.
    localparam logic [OPCODE_W-1:0] OP_FILTER     = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_WRITE_COEF = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR      = 2'd2;

    // Coefficient selects within one section.
    localparam logic [COEF_SEL_W-1:0] COEF_B0 = 3'd0;
    localparam logic [COEF_SEL_W-1:0] COEF_B1 = 3'd1;
    localparam logic [COEF_SEL_W-1:0] COEF_B2 = 3'd2;
    localparam logic [COEF_SEL_W-1:0] COEF_A1 = 3'd3;
    localparam logic [COEF_SEL_W-1:0] COEF_A2 = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SECTION_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_GAIN   = 1'b1;

    // Control for the shared multiply-accumulate unit.
    typedef struct packed {
        logic mul_en;
        logic acc_clr;
        logic acc_en;
        logic acc_sub;
    } t_mac_ctl;

endpackage

>>> rtl/bqc_if.sv
// Handshake interfaces of the biquad cascade filter core: input items,
// result items and configuration writes. Depends on bqc_pkg.
interface bqc_in_if #(
    parameter int SAMPLE_WIDTH = bqc_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = bqc_pkg::COEF_WIDTH_DEF
);
    logic                                valid;
    logic                                ready;
    logic [bqc_pkg::OPCODE_W-1:0]        opcode;
    logic signed [SAMPLE_WIDTH-1:0]      sample_in;
    logic [bqc_pkg::SEC_SEL_W-1:0]       section_select;
    logic [bqc_pkg::COEF_SEL_W-1:0]      coef_select;
    logic signed [COEF_WIDTH-1:0]        coef_value;

    modport source (output valid, opcode, sample_in, section_select, coef_select,
                    coef_value, input ready);
    modport sink   (input valid, opcode, sample_in, section_select, coef_select,
                    coef_value, output ready);
endinterface

interface bqc_out_if #(
    parameter int SAMPLE_WIDTH = bqc_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           clipped;

    modport source (output valid, sample_out, clipped, input ready);
    modport sink   (input valid, sample_out, clipped, output ready);
endinterface

interface bqc_cfg_if #(
    parameter int DATA_WIDTH = bqc_pkg::COEF_WIDTH_DEF
);
    logic                            valid;
    logic                            ready;
    logic [bqc_pkg::CFG_IDX_W-1:0]   index;
    logic [DATA_WIDTH-1:0]           data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/bqc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bqc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 40,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/bqc_mac.sv
// Shared multiply-accumulate unit: one signed multiplier, a registered product,
// an exact accumulator and the two round-and-saturate stages. Depends on bqc_pkg.
module bqc_mac #(
    parameter int SAMPLE_WIDTH = bqc_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = bqc_pkg::COEF_WIDTH_DEF
) (
    input  logic                                           i_clk,
    input  bqc_pkg::t_mac_ctl                              i_ctl,
    input  logic signed [COEF_WIDTH-1:0]                   i_coef,
    input  logic signed [SAMPLE_WIDTH+bqc_pkg::GUARD_BITS-1:0] i_operand,
    output logic signed [SAMPLE_WIDTH+bqc_pkg::GUARD_BITS-1:0] o_sec_y,
    output logic                                           o_sec_clip,
    output logic signed [SAMPLE_WIDTH-1:0]                 o_out_y,
    output logic                                           o_out_clip
);

    localparam int SIG_W     = SAMPLE_WIDTH + bqc_pkg::GUARD_BITS;
    localparam int PROD_W    = COEF_WIDTH + SIG_W;
    localparam int ACC_W     = PROD_W + 3;
    localparam int SEC_SHIFT = COEF_WIDTH - bqc_pkg::COEF_INT_BITS;
    localparam int OUT_SHIFT = SEC_SHIFT + bqc_pkg::GUARD_BITS;
    localparam logic signed [ACC_W-1:0] SEC_HALF = ACC_W'(1) << (SEC_SHIFT - 1);
    localparam logic signed [ACC_W-1:0] OUT_HALF = ACC_W'(1) << (OUT_SHIFT - 1);

    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  w_prod_ext;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  w_sec_rnd;
    logic signed [ACC_W-1:0]  w_sec_sh;
    logic signed [ACC_W-1:0]  w_out_rnd;
    logic signed [ACC_W-1:0]  w_out_sh;
    logic                     w_sec_ok;
    logic                     w_out_ok;

    // Multiplier, registered before the accumulator.
    assign w_prod     = PROD_W'(i_coef) * PROD_W'(i_operand);
    assign w_prod_ext = ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= w_prod;
        end
        if (i_ctl.acc_clr) begin
            r_acc <= '0;
        end else if (i_ctl.acc_en) begin
            r_acc <= i_ctl.acc_sub ? (r_acc - w_prod_ext) : (r_acc + w_prod_ext);
        end
    end

    // Section result: round half up by the coefficient fraction, saturate to a signal.
    assign w_sec_rnd = r_acc + SEC_HALF;
    assign w_sec_sh  = w_sec_rnd >>> SEC_SHIFT;
    assign w_sec_ok  = (&w_sec_sh[ACC_W-1:SIG_W-1]) || !(|w_sec_sh[ACC_W-1:SIG_W-1]);
    assign o_sec_clip = !w_sec_ok;
    assign o_sec_y = w_sec_ok ? w_sec_sh[SIG_W-1:0] :
                     (w_sec_sh[ACC_W-1] ? {1'b1, {(SIG_W-1){1'b0}}}
                                        : {1'b0, {(SIG_W-1){1'b1}}});

    // Output result: also drop the guard bits, saturate to a sample.
    assign w_out_rnd = r_acc + OUT_HALF;
    assign w_out_sh  = w_out_rnd >>> OUT_SHIFT;
    assign w_out_ok  = (&w_out_sh[ACC_W-1:SAMPLE_WIDTH-1])
                    || !(|w_out_sh[ACC_W-1:SAMPLE_WIDTH-1]);
    assign o_out_clip = !w_out_ok;
    assign o_out_y = w_out_ok ? w_out_sh[SAMPLE_WIDTH-1:0] :
                     (w_out_sh[ACC_W-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                                        : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}});

endmodule

>>> rtl/biquad_cascade_filter_core.sv
// Top level of the biquad cascade filter core: sequencer, delay registers,
// configuration registers and result register. Depends on bqc_pkg, bqc_if,
// bqc_ram and bqc_mac.
//
//  Channel   Direction  Handshake      Carries
//  i_in      sink       valid/ready    opcode, sample_in, section/coef select, coef_value
//  o_out     source     valid/ready    sample_out, clipped
//  i_cfg     sink       valid/ready    register index, data (always ready)
//
// A filter item runs through each active section and then the gain stage
// before its result is shown; the pace is set by the single shared multiplier
// and the registered coefficient memory read, and no new item is taken while
// the block is busy. Coefficient writes and delay clears complete in the idle
// state and give no result. Reset clears the delays, the sequencer and the
// section count and sets the gain to unity; coefficients are not cleared. A
// stalled result holds the block until it is taken.
module biquad_cascade_filter_core #(
    parameter int MAX_SECTIONS = bqc_pkg::MAX_SECTIONS_DEF,
    parameter int SAMPLE_WIDTH = bqc_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = bqc_pkg::COEF_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bqc_in_if.sink      i_in,
    bqc_out_if.source   o_out,
    bqc_cfg_if.sink     i_cfg
);

    localparam int SIG_W  = SAMPLE_WIDTH + bqc_pkg::GUARD_BITS;
    localparam int DEPTH  = MAX_SECTIONS * bqc_pkg::COEFS_PER_SECTION;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SEC_W  = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int CNT_W  = $clog2(MAX_SECTIONS + 1);
    localparam int CMP_W  = (CNT_W > bqc_pkg::SEC_COUNT_W) ? CNT_W : bqc_pkg::SEC_COUNT_W;
    localparam int WA_W   = 6;
    // Steps of one section: fetch at 0..4, multiply at 1..5, accumulate at 2..6.
    localparam logic [2:0] K_LAST_SEC  = 3'd6;
    localparam logic [2:0] K_LAST_GAIN = 3'd2;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SEC  = 5'b00010,
        S_UPD  = 5'b00100,
        S_GAIN = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state                          r_state;
    logic [2:0]                      r_k;
    logic [SEC_W-1:0]                r_sec;
    logic [AW-1:0]                   r_base;
    logic [CNT_W-1:0]                r_n;
    logic                            r_clip;
    logic signed [SIG_W-1:0]         r_x;
    logic signed [SIG_W-1:0]         r_x1 [MAX_SECTIONS];
    logic signed [SIG_W-1:0]         r_x2 [MAX_SECTIONS];
    logic signed [SIG_W-1:0]         r_y1 [MAX_SECTIONS];
    logic signed [SIG_W-1:0]         r_y2 [MAX_SECTIONS];
    logic [bqc_pkg::SEC_COUNT_W-1:0] r_section_count;
    logic signed [COEF_WIDTH-1:0]    r_gain;
    logic signed [SAMPLE_WIDTH-1:0]  r_sample_out;
    logic                            r_clipped;

    logic                            w_in_acc;
    logic                            w_last_sec;
    logic [CMP_W-1:0]                w_cnt_ext;
    logic [CNT_W-1:0]                w_n;
    logic [WA_W-1:0]                 w_waddr;
    logic                            w_we;
    logic [AW-1:0]                   w_raddr;
    logic [COEF_WIDTH-1:0]           w_rdata;
    logic signed [COEF_WIDTH-1:0]    w_coef;
    logic signed [SIG_W-1:0]         w_operand;
    bqc_pkg::t_mac_ctl               w_ctl;
    logic signed [SIG_W-1:0]         w_sec_y;
    logic                            w_sec_clip;
    logic signed [SAMPLE_WIDTH-1:0]  w_out_y;
    logic                            w_out_clip;

    // Handshakes.
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign o_out.valid      = (r_state == S_OUT);
    assign o_out.sample_out = r_sample_out;
    assign o_out.clipped    = r_clipped;

    // Active section count, limited to the sections built.
    assign w_cnt_ext  = CMP_W'(r_section_count);
    assign w_n        = (w_cnt_ext > CMP_W'(MAX_SECTIONS)) ? CNT_W'(MAX_SECTIONS)
                                                           : CNT_W'(w_cnt_ext);
    assign w_last_sec = ((CNT_W'(r_sec) + CNT_W'(1)) == r_n);

    // Coefficient write address and range check.
    assign w_waddr = WA_W'(i_in.section_select) * WA_W'(bqc_pkg::COEFS_PER_SECTION)
                   + WA_W'(i_in.coef_select);
    assign w_we = w_in_acc && (i_in.opcode == bqc_pkg::OP_WRITE_COEF)
               && (i_in.coef_select <= bqc_pkg::COEF_A2)
               && (WA_W'(i_in.section_select) < WA_W'(MAX_SECTIONS));
    assign w_raddr = r_base + AW'(r_k);

    bqc_ram #(
        .WIDTH (COEF_WIDTH),
        .DEPTH (DEPTH)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(w_waddr)),
        .i_wdata (i_in.coef_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Operand and control for the shared multiply-accumulate unit.
    always_comb begin
        w_ctl     = '0;
        w_operand = r_x;
        w_coef    = signed'(w_rdata);
        unique case (r_state)
            S_SEC: begin
                w_ctl.acc_clr = (r_k == 3'd0);
                w_ctl.mul_en  = (r_k >= 3'd1) && (r_k <= 3'd5);
                w_ctl.acc_en  = (r_k >= 3'd2);
                w_ctl.acc_sub = (r_k >= 3'd5);
                unique case (r_k)
                    3'd2:    w_operand = r_x1[r_sec];
                    3'd3:    w_operand = r_x2[r_sec];
                    3'd4:    w_operand = r_y1[r_sec];
                    3'd5:    w_operand = r_y2[r_sec];
                    default: w_operand = r_x;
                endcase
            end
            S_GAIN: begin
                w_coef        = r_gain;
                w_ctl.mul_en  = (r_k == 3'd0);
                w_ctl.acc_clr = (r_k == 3'd0);
                w_ctl.acc_en  = (r_k == 3'd1);
            end
            default: begin
                w_ctl = '0;
            end
        endcase
    end

    bqc_mac #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_mac (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_coef     (w_coef),
        .i_operand  (w_operand),
        .o_sec_y    (w_sec_y),
        .o_sec_clip (w_sec_clip),
        .o_out_y    (w_out_y),
        .o_out_clip (w_out_clip)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_section_count <= '0;
            r_gain          <= COEF_WIDTH'(1) << (COEF_WIDTH - bqc_pkg::COEF_INT_BITS);
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                bqc_pkg::CFG_SECTION_COUNT:
                    r_section_count <= i_cfg.data[bqc_pkg::SEC_COUNT_W-1:0];
                bqc_pkg::CFG_OUTPUT_GAIN:
                    r_gain <= signed'(i_cfg.data[COEF_WIDTH-1:0]);
                default: begin
                end
            endcase
        end
    end

    // Sequencer and delay registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_sec   <= '0;
            r_base  <= '0;
            r_n     <= '0;
            r_clip  <= 1'b0;
            for (int i = 0; i < MAX_SECTIONS; i++) begin
                r_x1[i] <= '0;
                r_x2[i] <= '0;
                r_y1[i] <= '0;
                r_y2[i] <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        unique case (i_in.opcode)
                            bqc_pkg::OP_FILTER: begin
                                r_x     <= {i_in.sample_in, {bqc_pkg::GUARD_BITS{1'b0}}};
                                r_n     <= w_n;
                                r_sec   <= '0;
                                r_base  <= '0;
                                r_k     <= '0;
                                r_clip  <= 1'b0;
                                r_state <= (w_n == '0) ? S_GAIN : S_SEC;
                            end
                            bqc_pkg::OP_CLEAR: begin
                                for (int i = 0; i < MAX_SECTIONS; i++) begin
                                    r_x1[i] <= '0;
                                    r_x2[i] <= '0;
                                    r_y1[i] <= '0;
                                    r_y2[i] <= '0;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SEC: begin
                    if (r_k == K_LAST_SEC) begin
                        r_state <= S_UPD;
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                S_UPD: begin
                    // Shift this section's delays and pass its output on.
                    r_x2[r_sec] <= r_x1[r_sec];
                    r_x1[r_sec] <= r_x;
                    r_y2[r_sec] <= r_y1[r_sec];
                    r_y1[r_sec] <= w_sec_y;
                    r_x         <= w_sec_y;
                    r_clip      <= r_clip | w_sec_clip;
                    r_k         <= '0;
                    if (w_last_sec) begin
                        r_state <= S_GAIN;
                    end else begin
                        r_sec   <= r_sec + SEC_W'(1);
                        r_base  <= r_base + AW'(bqc_pkg::COEFS_PER_SECTION);
                        r_state <= S_SEC;
                    end
                end
                S_GAIN: begin
                    if (r_k == K_LAST_GAIN) begin
                        r_sample_out <= w_out_y;
                        r_clipped    <= r_clip | w_out_clip;
                        r_state      <= S_OUT;
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                S_OUT: begin
                    if (o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The block never takes an item while a result is on offer.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while a result is pending");

    // A filter item always leaves the idle state.
    a_filter_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in.opcode == bqc_pkg::OP_FILTER)) |=> !i_in.ready)
        else $error("filter item did not start the sequencer");

    // Section index stays within the active count while sections run.
    a_sec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SEC) || (r_state == S_UPD)) |-> (CNT_W'(r_sec) < r_n))
        else $error("section index beyond active count");

    // A taken result returns the block to accepting items.
    a_out_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready) |=> (i_in.ready && !o_out.valid))
        else $error("block not idle after result taken");

endmodule
